@@ rtl/core/sn83_pkg.sv @@
// Package for the 8.3 short-name encoder: byte constants, field sizes and
// the letter upcase helper. Used by the encoder core; depends on nothing.
package sn83_pkg;

  localparam int unsigned NAME_BYTES = 8;
  localparam int unsigned EXT_BYTES  = 3;
  localparam int unsigned NAME_IDX_W = $clog2(NAME_BYTES);
  localparam int unsigned CNT_W      = 4;
  localparam int unsigned EXT_CNT_W  = 2;

  localparam logic [7:0]       SPACE_BYTE = 8'h20;
  localparam logic [7:0]       DOT_BYTE   = 8'h2E;
  localparam logic [CNT_W-1:0] COUNT_MAX  = 4'd15;

  typedef logic [7:0] byte_t;

  // Only the letters a to z are folded to upper case.
  function automatic byte_t upcase(input byte_t c);
    byte_t r;
    r = c;
    if (c >= 8'h61 && c <= 8'h7A) begin
      r = c - 8'h20;
    end
    return r;
  endfunction

endpackage

@@ rtl/core/short_name_8_3_encoder.sv @@
// 8.3 short-name encoder: takes a file name one byte per beat and, on the
// beat marked last, delivers the eleven-byte on-disk form. Uses sn83_pkg.
// The result beat is registered: it is valid in the cycle after the last beat.
// Throughput: one input beat per cycle; a non-last beat is taken even while a
// result waits, and a last beat needs the output register free or draining.
// Reset (rst_ni low, asynchronous) empties the name state and the output.
module short_name_8_3_encoder
  import sn83_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  char_byte_i,
  input  logic        present_i,
  input  logic        last_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] name_part_o,
  output logic [23:0] ext_part_o
);

  // Name state. It is updated by every accepted beat that carries a byte,
  // and it returns to its reset value after each completed name.
  byte_t                head_q [NAME_BYTES];
  byte_t                head_d [NAME_BYTES];
  byte_t                ext_q  [EXT_BYTES];
  byte_t                ext_d  [EXT_BYTES];
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [CNT_W-1:0]     dot_pos_q, dot_pos_d;
  logic [EXT_CNT_W-1:0] ext_cnt_q, ext_cnt_d;
  logic                 dot_seen_q, dot_seen_d;
  logic                 only_dots_q, only_dots_d;

  // State after the current beat's byte, before the end-of-name clear.
  byte_t                head_upd [NAME_BYTES];
  byte_t                ext_upd  [EXT_BYTES];
  logic [CNT_W-1:0]     cnt_upd;
  logic [CNT_W-1:0]     dot_pos_upd;
  logic [EXT_CNT_W-1:0] ext_cnt_upd;
  logic                 dot_seen_upd;
  logic                 only_dots_upd;

  // Output register.
  logic        out_valid_q, out_valid_d;
  logic [63:0] name_part_q, name_part_d;
  logic [23:0] ext_part_q, ext_part_d;

  logic       in_acc;
  logic       take_byte;
  logic       is_dot;
  logic [CNT_W-1:0] stem_len;
  logic       dot_name;

  // A result can only be produced by a last beat, so only that beat has to
  // wait for room in the output register.
  assign in_ready_o = !out_valid_q || out_ready_i || !last_i;
  assign in_acc     = in_valid_i && in_ready_o;
  assign take_byte  = in_acc && present_i;
  assign is_dot     = (char_byte_i == DOT_BYTE);

  // Fold one byte into the name state.
  always_comb begin
    head_upd      = head_q;
    ext_upd       = ext_q;
    cnt_upd       = cnt_q;
    dot_pos_upd   = dot_pos_q;
    ext_cnt_upd   = ext_cnt_q;
    dot_seen_upd  = dot_seen_q;
    only_dots_upd = only_dots_q;
    if (take_byte) begin
      // Only the first eight bytes are kept; the count runs on to show that
      // the name was longer.
      if (cnt_q < CNT_W'(NAME_BYTES)) begin
        head_upd[cnt_q[NAME_IDX_W-1:0]] = char_byte_i;
      end
      if (is_dot) begin
        // A later dot throws away any extension gathered so far.
        dot_seen_upd = 1'b1;
        dot_pos_upd  = cnt_q;
        for (int i = 0; i < EXT_BYTES; i++) begin
          ext_upd[i] = SPACE_BYTE;
        end
        ext_cnt_upd = '0;
      end else begin
        only_dots_upd = 1'b0;
        if (dot_seen_q && (ext_cnt_q < EXT_CNT_W'(EXT_BYTES))) begin
          ext_upd[ext_cnt_q] = char_byte_i;
          ext_cnt_upd        = ext_cnt_q + 1'b1;
        end
      end
      if (cnt_q != COUNT_MAX) begin
        cnt_upd = cnt_q + 1'b1;
      end
    end
  end

  // Format the on-disk form from the updated state.
  always_comb begin
    dot_name = only_dots_upd && ((cnt_upd == 4'd1) || (cnt_upd == 4'd2));
    stem_len = dot_seen_upd ? dot_pos_upd : cnt_upd;
    if (stem_len > CNT_W'(NAME_BYTES)) begin
      stem_len = CNT_W'(NAME_BYTES);
    end
    name_part_d = name_part_q;
    ext_part_d  = ext_part_q;
    if (in_acc && last_i) begin
      for (int i = 0; i < NAME_BYTES; i++) begin
        if (dot_name) begin
          // The names "." and ".." pass through as they are.
          name_part_d[63-8*i -: 8] = (CNT_W'(i) < cnt_upd) ? DOT_BYTE : SPACE_BYTE;
        end else begin
          name_part_d[63-8*i -: 8] =
            (CNT_W'(i) < stem_len) ? upcase(head_upd[i]) : SPACE_BYTE;
        end
      end
      for (int i = 0; i < EXT_BYTES; i++) begin
        if (!dot_name && (EXT_CNT_W'(i) < ext_cnt_upd)) begin
          ext_part_d[23-8*i -: 8] = upcase(ext_upd[i]);
        end else begin
          ext_part_d[23-8*i -: 8] = SPACE_BYTE;
        end
      end
    end
  end

  // Next state: the updated state, or the reset value once a name is done.
  always_comb begin
    head_d      = head_upd;
    ext_d       = ext_upd;
    cnt_d       = cnt_upd;
    dot_pos_d   = dot_pos_upd;
    ext_cnt_d   = ext_cnt_upd;
    dot_seen_d  = dot_seen_upd;
    only_dots_d = only_dots_upd;
    if (in_acc && last_i) begin
      for (int i = 0; i < NAME_BYTES; i++) begin
        head_d[i] = SPACE_BYTE;
      end
      for (int i = 0; i < EXT_BYTES; i++) begin
        ext_d[i] = SPACE_BYTE;
      end
      cnt_d       = '0;
      dot_pos_d   = '0;
      ext_cnt_d   = '0;
      dot_seen_d  = 1'b0;
      only_dots_d = 1'b1;
    end
  end

  // The output beat stays until taken; a last beat refills it in the cycle
  // the old beat drains.
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (in_acc && last_i) begin
      out_valid_d = 1'b1;
    end
  end

  // The byte stores have a defined reset value, so they are cleared here too.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NAME_BYTES; i++) begin
        head_q[i] <= SPACE_BYTE;
      end
      for (int i = 0; i < EXT_BYTES; i++) begin
        ext_q[i] <= SPACE_BYTE;
      end
      cnt_q       <= '0;
      dot_pos_q   <= '0;
      ext_cnt_q   <= '0;
      dot_seen_q  <= 1'b0;
      only_dots_q <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      head_q      <= head_d;
      ext_q       <= ext_d;
      cnt_q       <= cnt_d;
      dot_pos_q   <= dot_pos_d;
      ext_cnt_q   <= ext_cnt_d;
      dot_seen_q  <= dot_seen_d;
      only_dots_q <= only_dots_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    name_part_q <= name_part_d;
    ext_part_q  <= ext_part_d;
  end

  assign out_valid_o = out_valid_q;
  assign name_part_o = name_part_q;
  assign ext_part_o  = ext_part_q;

endmodule

@@ rtl/core/sn83_checker.sv @@
// Port-level checks for the 8.3 short-name encoder, bound to its top level.
// Depends only on the encoder's ports.
module sn83_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        last_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [63:0] name_part_o,
  input logic [23:0] ext_part_o
);

  // The output register comes out of reset empty.
  a_reset_empty: assert property (@(posedge clk_i) $rose(rst_ni) |-> !out_valid_o)
    else $error("output beat valid right after reset");

  // A stalled result beat holds its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(name_part_o) && $stable(ext_part_o))
    else $error("stalled result beat changed");

  // Every accepted last beat produces a result in the next cycle.
  a_last_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && last_i |=> out_valid_o)
    else $error("last beat gave no result");

  // A beat that is not last never creates a result of its own.
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_valid_i && in_ready_o && last_i) && (!out_valid_o || out_ready_i)
      |=> !out_valid_o)
    else $error("result appeared without a last beat");

  // The first name byte is upper-cased, a dot or a space: never a to z.
  a_first_upcased: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(name_part_o[63:56] >= 8'h61 && name_part_o[63:56] <= 8'h7A))
    else $error("lower-case letter in name part");

endmodule

bind short_name_8_3_encoder sn83_checker u_sn83_checker (.*);

@@ tb/short_name_8_3_encoder_tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for short_name_8_3_encoder: streams file names one byte per beat
// and checks each 8.3 result against a behavioral tracker. Depends on sn83_pkg and the RTL.
module short_name_8_3_encoder_tb;
  import sn83_pkg::*;

  localparam int unsigned STALL_LIMIT = 2000;  // cycles with no beat moving on either side
  localparam int unsigned HOLD_CYCLES = 300;   // long receiver hold-off for the fill test
  localparam int unsigned TAIL_CYCLES = 8;     // settle time after the last result

  // One expected result: the name field and the extension field as the block packs them.
  typedef struct packed {
    logic [63:0] name_bytes;
    logic [23:0] ext_bytes;
  } short_name_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  char_byte_i = 8'h00;
  logic        present_i = 1'b0;
  logic        last_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [63:0] name_part_o;
  logic [23:0] ext_part_o;

  short_name_8_3_encoder u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .char_byte_i (char_byte_i),
    .present_i   (present_i),
    .last_i      (last_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .name_part_o (name_part_o),
    .ext_part_o  (ext_part_o)
  );

  always #4 clk_i = ~clk_i;

  // Idle rates in percent for the two sides, and the request for one long hold-off.
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  bit          hold_req = 1'b0;

  int unsigned mismatches = 0;
  int unsigned beats_taken = 0;  // accepted beats that carry a byte or end a name

  short_name_t pending_names[$];

  // Tracker state: a copy of what the encoder has gathered for the name in flight.
  byte_t       head_seen [NAME_BYTES];
  byte_t       ext_seen [EXT_BYTES];
  logic [3:0]  seen_cnt;
  logic        dot_flag;
  logic [3:0]  dot_idx;
  logic [1:0]  ext_cnt;
  logic        all_dots;

  function automatic void clear_tracker();
    head_seen = '{default: SPACE_BYTE};
    ext_seen  = '{default: SPACE_BYTE};
    seen_cnt  = '0;
    dot_flag  = 1'b0;
    dot_idx   = '0;
    ext_cnt   = '0;
    all_dots  = 1'b1;
  endfunction

  // Folds a to z to upper case and leaves every other byte alone.
  function automatic byte_t fold_letter(byte_t c);
    return (c >= 8'h61 && c <= 8'h7A) ? (c & 8'hDF) : c;
  endfunction

  // Advances the tracker by one accepted beat. A beat marked last queues the
  // 8.3 form of the name gathered so far and starts a fresh name.
  function automatic void track_beat(byte_t c, logic p, logic l);
    byte_t       shown_name [NAME_BYTES];
    byte_t       shown_ext [EXT_BYTES];
    int unsigned stem_len;
    short_name_t want;

    if (p) begin
      if (seen_cnt < NAME_BYTES) begin
        head_seen[seen_cnt] = c;
      end
      if (c == DOT_BYTE) begin
        // A later dot throws away any extension gathered after an earlier one.
        dot_flag = 1'b1;
        dot_idx  = seen_cnt;
        ext_seen = '{default: SPACE_BYTE};
        ext_cnt  = '0;
      end else begin
        all_dots = 1'b0;
        if (dot_flag && ext_cnt < EXT_BYTES) begin
          ext_seen[ext_cnt] = c;
          ext_cnt++;
        end
      end
      if (seen_cnt < COUNT_MAX) begin
        seen_cnt++;
      end
    end

    if (l) begin
      shown_name = '{default: SPACE_BYTE};
      shown_ext  = '{default: SPACE_BYTE};
      if (all_dots && (seen_cnt == 4'd1 || seen_cnt == 4'd2)) begin
        // "." and ".." are kept as they are, with no extension.
        for (int i = 0; i < seen_cnt; i++) begin
          shown_name[i] = DOT_BYTE;
        end
      end else begin
        stem_len = dot_flag ? dot_idx : seen_cnt;
        if (stem_len > NAME_BYTES) begin
          stem_len = NAME_BYTES;
        end
        for (int i = 0; i < stem_len; i++) begin
          shown_name[i] = fold_letter(head_seen[i]);
        end
        for (int i = 0; i < ext_cnt; i++) begin
          shown_ext[i] = fold_letter(ext_seen[i]);
        end
      end
      want = '0;
      for (int i = 0; i < NAME_BYTES; i++) begin
        want.name_bytes = {want.name_bytes[55:0], shown_name[i]};
      end
      for (int i = 0; i < EXT_BYTES; i++) begin
        want.ext_bytes = {want.ext_bytes[15:0], shown_ext[i]};
      end
      pending_names.push_back(want);
      clear_tracker();
    end
  endfunction

  // Offers one beat, with a random idle gap first, and waits until it is taken.
  // Valid is left high afterwards so that back-to-back beats never drop it.
  task automatic send_beat(input byte_t c, input logic p, input logic l);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      char_byte_i <= 8'($urandom);
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    char_byte_i <= c;
    present_i   <= p;
    last_i      <= l;
    do begin
      @(posedge clk_i);
    end while (!in_ready_o);
    track_beat(c, p, l);
    if (p || l) begin
      beats_taken++;
    end
  endtask

  // Sends a name given as text; the empty text is sent as a single empty last beat.
  task automatic send_text(input string s);
    if (s.len() == 0) begin
      send_beat(8'($urandom), 1'b0, 1'b1);
    end else begin
      for (int i = 0; i < s.len(); i++) begin
        send_beat(byte_t'(s[i]), 1'b1, i == s.len() - 1);
      end
    end
  endtask

  // Byte mix weighted toward dots, letters and the edges of the a to z range.
  function automatic byte_t pick_char();
    byte_t edges [7] = '{8'h60, 8'h7B, 8'h40, 8'h5B, 8'h00, 8'hFF, 8'h20};
    case ($urandom_range(9))
      0, 1:    return DOT_BYTE;
      2, 3, 4: return byte_t'($urandom_range(8'h7A, 8'h61));
      5:       return byte_t'($urandom_range(8'h5A, 8'h41));
      6:       return byte_t'($urandom_range(8'h39, 8'h30));
      7:       return edges[$urandom_range(6)];
      default: return byte_t'($urandom_range(255));
    endcase
  endfunction

  // One well-formed name with random content. Some names are dot-only, some
  // run past the counter limit, some end with an empty beat, and empty
  // non-last beats are mixed in as noise.
  task automatic send_random_name();
    int unsigned kind;
    int unsigned len;
    bit          empty_tail;
    byte_t       c;

    kind = $urandom_range(11);
    if (kind == 0) begin
      len = $urandom_range(3, 1);
    end else if (kind == 1) begin
      len = $urandom_range(22, 16);
    end else begin
      len = $urandom_range(12);
    end
    empty_tail = (len == 0) || ($urandom_range(5) == 0);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(9) == 0) begin
        send_beat(8'($urandom), 1'b0, 1'b0);
      end
      c = (kind == 0) ? DOT_BYTE : pick_char();
      send_beat(c, 1'b1, !empty_tail && (i == len - 1));
    end
    if (empty_tail) begin
      send_beat(8'($urandom), 1'b0, 1'b1);
    end
  endtask

  // Hand-picked names: the dot names and their three-dot neighbor, the empty
  // name, a name whose bytes are split by empty beats, case edges with a later
  // dot and a zero byte, and a name long enough to saturate both counters.
  task automatic test_directed_names();
    send_idle_pct = 24;
    recv_idle_pct = 66;
    send_text(".");
    send_text("..");
    send_text("...");
    send_text("");
    send_beat("a", 1'b1, 1'b0);
    send_beat(8'hFF, 1'b0, 1'b0);
    send_beat("b", 1'b1, 1'b0);
    send_beat(8'h00, 1'b0, 1'b1);
    send_beat(8'h60, 1'b1, 1'b0);
    send_beat("a", 1'b1, 1'b0);
    send_beat("z", 1'b1, 1'b0);
    send_beat(8'h7B, 1'b1, 1'b0);
    send_beat(DOT_BYTE, 1'b1, 1'b0);
    send_beat("q", 1'b1, 1'b0);
    send_beat(DOT_BYTE, 1'b1, 1'b0);
    send_beat(8'h00, 1'b1, 1'b0);
    send_beat(8'hFF, 1'b1, 1'b1);
    send_text("abcdefghijklmnopq.rstu");
  endtask

  task automatic test_random_names(input int unsigned send_pct, input int unsigned recv_pct,
                                   input int unsigned count);
    int unsigned stop_at;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    stop_at = beats_taken + count;
    while (beats_taken < stop_at) begin
      send_random_name();
    end
  endtask

  // The receiver holds off for a long stretch while the sender keeps going,
  // so a finished name sits in the output and the next last beat is stalled.
  task automatic test_output_stall();
    int unsigned stop_at;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req = 1'b1;
    stop_at = beats_taken + 70;
    while (beats_taken < stop_at) begin
      send_random_name();
    end
  endtask

  // Receiver side: random ready, or a counted hold-off when one is requested.
  initial begin : drive_out_ready
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_ready_i <= 1'b0;
        hold_left--;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic flag_mismatch(input string what, input logic [63:0] want,
                               input logic [63:0] got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t: %s mismatch: expected %h, got %h", $realtime, what, want, got);
    end
  endtask

  // Each result beat is checked against the oldest queued name.
  always @(posedge clk_i) begin : check_names
    short_name_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_names.size() == 0) begin
        flag_mismatch("unexpected result", '0, name_part_o);
      end else begin
        want = pending_names.pop_front();
        if (name_part_o !== want.name_bytes) begin
          flag_mismatch("name_part", want.name_bytes, name_part_o);
        end
        if (ext_part_o !== want.ext_bytes) begin
          flag_mismatch("ext_part", 64'(want.ext_bytes), 64'(ext_part_o));
        end
      end
    end
  end

  // Ends the run if neither side moves a beat for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("short_name_8_3_encoder_tb: FAIL");
    $finish;
  end

  initial begin
    clear_tracker();
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);

    test_directed_names();
    test_random_names(24, 66, 190);
    test_random_names(66, 24, 190);
    test_random_names(0, 0, 160);
    test_output_stall();
    in_valid_i <= 1'b0;

    // Drain whatever is still owed, then give the block time to show any extra beat.
    while (pending_names.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("short_name_8_3_encoder_tb: PASS");
    end else begin
      $display("short_name_8_3_encoder_tb: FAIL");
    end
    $finish;
  end

endmodule
